@@ rtl/lspf_pkg.sv @@
// ----------------------------------------------------------------------------
// lspf_pkg: shared definitions for the least-squares plane fit core
// Widths, operation step counts, state types and the solve program table.
// ----------------------------------------------------------------------------
`default_nettype none

package lspf_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int MAX_POINTS_DEF = 4096;
  localparam int WIDE           = 128;
  localparam int OPW            = 64;
  localparam int SLOPE_W        = 32;
  localparam int SPREAD_W       = 24;
  localparam int MUL_STEPS      = 64;
  localparam int DIV_STEPS      = 128;
  localparam int SQRT_STEPS     = 32;
  localparam int TERM_COUNT     = 27;
  localparam int TERM_W         = 5;
  localparam int CNT_W          = 7;

  typedef struct packed {
    logic [OPW-1:0] xx;
    logic [OPW-1:0] yy;
    logic [OPW-1:0] zz;
    logic [OPW-1:0] xy;
    logic [OPW-1:0] xz;
    logic [OPW-1:0] yz;
    logic [OPW-1:0] x;
    logic [OPW-1:0] y;
    logic [OPW-1:0] z;
    logic [OPW-1:0] n;
  } sums_t;

  typedef struct packed {
    logic [SLOPE_W-1:0]  slope_x;
    logic [SLOPE_W-1:0]  slope_y;
    logic [SLOPE_W-1:0]  offset;
    logic [SPREAD_W-1:0] z_spread;
    logic                status;
  } fit_t;

  typedef enum logic [3:0] {
    OPD_XX, OPD_YY, OPD_ZZ, OPD_XY, OPD_XZ, OPD_YZ,
    OPD_X, OPD_Y, OPD_Z, OPD_N, OPD_ONE
  } opnd_e;

  typedef enum logic [2:0] {
    GRP_VAR, GRP_NN, GRP_DET, GRP_DA, GRP_DB, GRP_DC
  } grp_e;

  typedef enum logic [1:0] {
    J_VAR, J_DA, J_DB, J_DC
  } job_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    opnd_e c;
    logic  neg;
    logic  last;
    grp_e  grp;
  } term_t;

  typedef enum logic [1:0] {
    T_IDLE, T_ACC, T_SOLVE, T_PUT
  } top_state_e;

  typedef enum logic [4:0] {
    S_IDLE, S_TERM_LD, S_MUL1, S_MUL_MID, S_MUL2, S_TERM_ACC, S_CHECK,
    S_DIV_LD, S_NEG_N, S_NEG_D, S_DIV, S_RND, S_INC, S_SAT,
    S_SQRT_LD, S_SQRT, S_SPREAD, S_FIN
  } solve_state_e;

  function automatic term_t mk(opnd_e a, opnd_e b, opnd_e c, logic neg, logic last,
                               grp_e grp);
    term_t t;
    t.a = a;
    t.b = b;
    t.c = c;
    t.neg = neg;
    t.last = last;
    t.grp = grp;
    return t;
  endfunction

  // Every quantity of the solve is a sum of signed triple products.
  function automatic term_t term_at(logic [TERM_W-1:0] idx);
    term_t t;
    unique case (idx)
      5'd0:  t = mk(OPD_N,  OPD_ZZ,  OPD_ONE, 1'b0, 1'b0, GRP_VAR);
      5'd1:  t = mk(OPD_Z,  OPD_Z,   OPD_ONE, 1'b1, 1'b1, GRP_VAR);
      5'd2:  t = mk(OPD_N,  OPD_N,   OPD_ONE, 1'b0, 1'b1, GRP_NN);
      5'd3:  t = mk(OPD_XX, OPD_YY,  OPD_N,   1'b0, 1'b0, GRP_DET);
      5'd4:  t = mk(OPD_XX, OPD_Y,   OPD_Y,   1'b1, 1'b0, GRP_DET);
      5'd5:  t = mk(OPD_XY, OPD_XY,  OPD_N,   1'b1, 1'b0, GRP_DET);
      5'd6:  t = mk(OPD_XY, OPD_Y,   OPD_X,   1'b0, 1'b0, GRP_DET);
      5'd7:  t = mk(OPD_X,  OPD_XY,  OPD_Y,   1'b0, 1'b0, GRP_DET);
      5'd8:  t = mk(OPD_X,  OPD_YY,  OPD_X,   1'b1, 1'b1, GRP_DET);
      5'd9:  t = mk(OPD_XZ, OPD_YY,  OPD_N,   1'b0, 1'b0, GRP_DA);
      5'd10: t = mk(OPD_XZ, OPD_Y,   OPD_Y,   1'b1, 1'b0, GRP_DA);
      5'd11: t = mk(OPD_XY, OPD_YZ,  OPD_N,   1'b1, 1'b0, GRP_DA);
      5'd12: t = mk(OPD_XY, OPD_Y,   OPD_Z,   1'b0, 1'b0, GRP_DA);
      5'd13: t = mk(OPD_X,  OPD_YZ,  OPD_Y,   1'b0, 1'b0, GRP_DA);
      5'd14: t = mk(OPD_X,  OPD_YY,  OPD_Z,   1'b1, 1'b1, GRP_DA);
      5'd15: t = mk(OPD_XX, OPD_YZ,  OPD_N,   1'b0, 1'b0, GRP_DB);
      5'd16: t = mk(OPD_XX, OPD_Y,   OPD_Z,   1'b1, 1'b0, GRP_DB);
      5'd17: t = mk(OPD_XZ, OPD_XY,  OPD_N,   1'b1, 1'b0, GRP_DB);
      5'd18: t = mk(OPD_XZ, OPD_Y,   OPD_X,   1'b0, 1'b0, GRP_DB);
      5'd19: t = mk(OPD_X,  OPD_XY,  OPD_Z,   1'b0, 1'b0, GRP_DB);
      5'd20: t = mk(OPD_X,  OPD_YZ,  OPD_X,   1'b1, 1'b1, GRP_DB);
      5'd21: t = mk(OPD_XX, OPD_YY,  OPD_Z,   1'b0, 1'b0, GRP_DC);
      5'd22: t = mk(OPD_XX, OPD_YZ,  OPD_Y,   1'b1, 1'b0, GRP_DC);
      5'd23: t = mk(OPD_XY, OPD_XY,  OPD_Z,   1'b1, 1'b0, GRP_DC);
      5'd24: t = mk(OPD_XY, OPD_YZ,  OPD_X,   1'b0, 1'b0, GRP_DC);
      5'd25: t = mk(OPD_XZ, OPD_XY,  OPD_Y,   1'b0, 1'b0, GRP_DC);
      5'd26: t = mk(OPD_XZ, OPD_YY,  OPD_X,   1'b1, 1'b1, GRP_DC);
      default: t = mk(OPD_ONE, OPD_ONE, OPD_ONE, 1'b0, 1'b1, GRP_DC);
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lspf_ifs.sv @@
// ----------------------------------------------------------------------------
// lspf_ifs: point and fit channels
// Valid/ready channels carrying one point item and one fit result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lspf_in_if;
  import lspf_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] px;
  logic signed [COORD_WIDTH-1:0] py;
  logic signed [COORD_WIDTH-1:0] pz;
  logic                          last;
  modport source (output valid, px, py, pz, last, input ready);
  modport sink (input valid, px, py, pz, last, output ready);
endinterface

interface lspf_out_if;
  import lspf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SLOPE_W-1:0]  slope_x;
  logic signed [SLOPE_W-1:0]  slope_y;
  logic signed [SLOPE_W-1:0]  offset;
  logic        [SPREAD_W-1:0] z_spread;
  logic                       status;
  modport source (output valid, slope_x, slope_y, offset, z_spread, status, input ready);
  modport sink (input valid, slope_x, slope_y, offset, z_spread, status, output ready);
endinterface

`default_nettype wire

@@ rtl/lspf_acc.sv @@
// ----------------------------------------------------------------------------
// lspf_acc: moment accumulator
// One shared signed multiplier forms the six products of a point in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_acc #(
  parameter int MAX_POINTS = lspf_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic                                   clear,
  input  wire logic signed [lspf_pkg::COORD_WIDTH-1:0] px,
  input  wire logic signed [lspf_pkg::COORD_WIDTH-1:0] py,
  input  wire logic signed [lspf_pkg::COORD_WIDTH-1:0] pz,
  output logic                                        busy,
  output lspf_pkg::sums_t                             sums
);
  import lspf_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int LG   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SQW  = 2 * CW + LG;
  localparam int LW   = CW + LG + 1;
  localparam int PW   = 2 * CW;

  logic signed [CW-1:0]  qx, qy, qz;
  logic signed [CW-1:0]  ma, mb;
  logic signed [PW-1:0]  mprod, preg;
  logic signed [SQW-1:0] sxx, syy, szz, sxy, sxz, syz;
  logic signed [LW-1:0]  sx, sy, sz;
  logic [CNTW-1:0]       cnt;
  logic [2:0]            step;
  logic                  take;

  always_comb begin
    ma = px;
    mb = px;
    if (busy) begin
      unique case (step)
        3'd0: begin ma = qy; mb = qy; end
        3'd1: begin ma = qz; mb = qz; end
        3'd2: begin ma = qx; mb = qy; end
        3'd3: begin ma = qx; mb = qz; end
        default: begin ma = qy; mb = qz; end
      endcase
    end
  end

  assign mprod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd5) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      qx   <= px;
      qy   <= py;
      qz   <= pz;
      take <= (cnt < CNTW'(MAX_POINTS));
    end
    if (start || busy) begin
      preg <= mprod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sxx <= '0;
      syy <= '0;
      szz <= '0;
      sxy <= '0;
      sxz <= '0;
      syz <= '0;
      sx  <= '0;
      sy  <= '0;
      sz  <= '0;
      cnt <= '0;
    end else if (busy && take) begin
      unique case (step)
        3'd0: begin
          sxx <= sxx + SQW'(preg);
          sx  <= sx + LW'(qx);
          sy  <= sy + LW'(qy);
          sz  <= sz + LW'(qz);
          cnt <= cnt + CNTW'(1);
        end
        3'd1: syy <= syy + SQW'(preg);
        3'd2: szz <= szz + SQW'(preg);
        3'd3: sxy <= sxy + SQW'(preg);
        3'd4: sxz <= sxz + SQW'(preg);
        default: syz <= syz + SQW'(preg);
      endcase
    end
  end

  assign sums.xx = OPW'(sxx);
  assign sums.yy = OPW'(syy);
  assign sums.zz = OPW'(szz);
  assign sums.xy = OPW'(sxy);
  assign sums.xz = OPW'(sxz);
  assign sums.yz = OPW'(syz);
  assign sums.x  = OPW'(sx);
  assign sums.y  = OPW'(sy);
  assign sums.z  = OPW'(sz);
  assign sums.n  = OPW'(cnt);

endmodule

`default_nettype wire

@@ rtl/lspf_solve.sv @@
// ----------------------------------------------------------------------------
// lspf_solve: normal equation solver
// A sequencer drives one shared 128-bit adder through shift-add multiplies,
// restoring divides and a bitwise square root.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_solve (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire lspf_pkg::sums_t sums,
  output logic                 busy,
  output lspf_pkg::fit_t       res
);
  import lspf_pkg::*;

  solve_state_e state, state_next;
  term_t        tm;
  job_e         job;

  logic [TERM_W-1:0]   term;
  logic [CNT_W-1:0]    cnt;
  logic [OPW-1:0]      mplier;
  logic [WIDE-1:0]     mcand, prod, acc;
  logic [WIDE-1:0]     var_r, nn_r, det_r, da_r, db_r, dc_r;
  logic [WIDE-1:0]     rr, nq, den, num_sel, den_sel, rr_sh;
  logic [WIDE-1:0]     add_a, add_b;
  logic                add_sub;
  logic [WIDE:0]       add_sum;
  logic                neg, rnd;
  logic [OPW-1:0]      sq_v, sq_res, sq_bit;
  logic [SLOPE_W-1:0]  lim, mag, r32;
  logic                sat;

  function automatic logic [OPW-1:0] opnd(opnd_e o, sums_t s);
    logic [OPW-1:0] v;
    unique case (o)
      OPD_XX:  v = s.xx;
      OPD_YY:  v = s.yy;
      OPD_ZZ:  v = s.zz;
      OPD_XY:  v = s.xy;
      OPD_XZ:  v = s.xz;
      OPD_YZ:  v = s.yz;
      OPD_X:   v = s.x;
      OPD_Y:   v = s.y;
      OPD_Z:   v = s.z;
      OPD_N:   v = s.n;
      default: v = OPW'(1);
    endcase
    return v;
  endfunction

  assign tm      = term_at(term);
  assign busy    = (state != S_IDLE);
  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {WIDE{add_sub}}} + (WIDE + 1)'(add_sub);
  assign rr_sh   = {rr[WIDE-2:0], nq[WIDE-1]};

  always_comb begin
    unique case (job)
      J_VAR:   num_sel = {var_r[WIDE-17:0], 16'd0};
      J_DA:    num_sel = {da_r[WIDE-17:0], 16'd0};
      J_DB:    num_sel = {db_r[WIDE-17:0], 16'd0};
      default: num_sel = {dc_r[WIDE-9:0], 8'd0};
    endcase
    den_sel = (job == J_VAR) ? nn_r : det_r;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat = (nq[WIDE-1:SLOPE_W] != '0) || (nq[SLOPE_W-1:0] > lim);
    mag = sat ? lim : nq[SLOPE_W-1:0];
    r32 = neg ? (32'd0 - mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    add_a = '0;
    add_b = '0;
    add_sub = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_TERM_LD;
        end
      end
      S_TERM_LD: state_next = S_MUL1;
      S_MUL1, S_MUL2: begin
        add_a = prod;
        add_b = mcand;
        add_sub = (cnt == CNT_W'(MUL_STEPS - 1));
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          state_next = (state == S_MUL1) ? S_MUL_MID : S_TERM_ACC;
        end
      end
      S_MUL_MID: state_next = S_MUL2;
      S_TERM_ACC: begin
        add_a = acc;
        add_b = prod;
        add_sub = tm.neg;
        state_next = (term == TERM_W'(TERM_COUNT - 1)) ? S_CHECK : S_TERM_LD;
      end
      S_CHECK: state_next = (sums.n == '0) ? S_FIN : S_DIV_LD;
      S_DIV_LD: state_next = (job == J_VAR) ? S_DIV : S_NEG_N;
      S_NEG_N: begin
        add_b = nq;
        add_sub = 1'b1;
        state_next = S_NEG_D;
      end
      S_NEG_D: begin
        add_b = den;
        add_sub = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        add_a = rr_sh;
        add_b = den;
        add_sub = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = (job == J_VAR) ? S_SQRT_LD : S_RND;
        end
      end
      S_RND: begin
        add_a = {rr[WIDE-2:0], 1'b0};
        add_b = den;
        add_sub = 1'b1;
        state_next = S_INC;
      end
      S_INC: begin
        add_a = nq;
        add_b = WIDE'(rnd);
        state_next = S_SAT;
      end
      S_SAT: state_next = (job == J_DC) ? S_FIN : S_DIV_LD;
      S_SQRT_LD: state_next = S_SQRT;
      S_SQRT: begin
        add_a = WIDE'(sq_v);
        add_b = WIDE'(sq_res | sq_bit);
        add_sub = 1'b1;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = S_SPREAD;
        end
      end
      S_SPREAD: state_next = (det_r == '0) ? S_FIN : S_DIV_LD;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        term <= '0;
        acc  <= '0;
      end
      S_TERM_LD: begin
        mplier <= opnd(tm.a, sums);
        mcand  <= WIDE'($signed(opnd(tm.b, sums)));
        prod   <= '0;
        cnt    <= '0;
      end
      S_MUL1, S_MUL2: begin
        if (mplier[0]) begin
          prod <= add_sum[WIDE-1:0];
        end
        mcand  <= {mcand[WIDE-2:0], 1'b0};
        mplier <= {1'b0, mplier[OPW-1:1]};
        cnt    <= cnt + CNT_W'(1);
      end
      S_MUL_MID: begin
        mplier <= opnd(tm.c, sums);
        mcand  <= prod;
        prod   <= '0;
        cnt    <= '0;
      end
      S_TERM_ACC: begin
        term <= term + TERM_W'(1);
        if (tm.last) begin
          acc <= '0;
          unique case (tm.grp)
            GRP_VAR: var_r <= add_sum[WIDE-1:0];
            GRP_NN:  nn_r  <= add_sum[WIDE-1:0];
            GRP_DET: det_r <= add_sum[WIDE-1:0];
            GRP_DA:  da_r  <= add_sum[WIDE-1:0];
            GRP_DB:  db_r  <= add_sum[WIDE-1:0];
            default: dc_r  <= add_sum[WIDE-1:0];
          endcase
        end else begin
          acc <= add_sum[WIDE-1:0];
        end
      end
      S_CHECK: begin
        res <= '{slope_x: '0, slope_y: '0, offset: '0, z_spread: '0,
                 status: (sums.n == '0)};
        job <= J_VAR;
      end
      S_DIV_LD: begin
        nq  <= num_sel;
        den <= den_sel;
        rr  <= '0;
        cnt <= '0;
        neg <= num_sel[WIDE-1] ^ den_sel[WIDE-1];
      end
      S_NEG_N: begin
        if (nq[WIDE-1]) begin
          nq <= add_sum[WIDE-1:0];
        end
      end
      S_NEG_D: begin
        if (den[WIDE-1]) begin
          den <= add_sum[WIDE-1:0];
        end
      end
      S_DIV: begin
        rr  <= add_sum[WIDE] ? add_sum[WIDE-1:0] : rr_sh;
        nq  <= {nq[WIDE-2:0], add_sum[WIDE]};
        cnt <= cnt + CNT_W'(1);
      end
      S_RND: rnd <= add_sum[WIDE];
      S_INC: nq <= add_sum[WIDE-1:0];
      S_SAT: begin
        unique case (job)
          J_DA:    res.slope_x <= r32;
          J_DB:    res.slope_y <= r32;
          default: res.offset  <= r32;
        endcase
        job <= job_e'(job + 2'd1);
      end
      S_SQRT_LD: begin
        sq_v   <= nq[OPW-1:0];
        sq_res <= '0;
        sq_bit <= OPW'(1) << (OPW - 2);
        cnt    <= '0;
      end
      S_SQRT: begin
        if (add_sum[WIDE]) begin
          sq_v   <= add_sum[OPW-1:0];
          sq_res <= (sq_res >> 1) | sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + CNT_W'(1);
      end
      S_SPREAD: begin
        if ((nq[WIDE-1:OPW] != '0) || (sq_res[OPW-1:SPREAD_W] != '0)) begin
          res.z_spread <= {SPREAD_W{1'b1}};
        end else begin
          res.z_spread <= sq_res[SPREAD_W-1:0];
        end
        res.status <= (det_r == '0);
        job <= J_DA;
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("Solve started while busy.");

  a_det_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_LD && job != J_VAR) |-> det_r != '0)
    else $error("Division by a zero determinant.");

  a_nn_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_LD && job == J_VAR) |-> nn_r != '0)
    else $error("Variance divided by zero count.");

endmodule

`default_nettype wire

@@ rtl/least_squares_plane_fit_core.sv @@
// ----------------------------------------------------------------------------
// least_squares_plane_fit_core: streaming least-squares plane fit
// Accumulates point moments and solves z = a*x + b*y + c on the last item.
// ----------------------------------------------------------------------------
// A point item occupies the accumulator after acceptance while the shared
// multiplier forms its six products; no new item is taken until it is done.
// An item marked last starts the solve (27 triple products of two 64-step
// multiplies, up to four 128-step divides, a 32-step root).
// The result sits in an output register; reset clears the sums and count,
// and they are cleared again after every result.
`default_nettype none

module least_squares_plane_fit_core #(
  parameter int MAX_POINTS = lspf_pkg::MAX_POINTS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  lspf_in_if.sink   point,
  lspf_out_if.source fit
);
  import lspf_pkg::*;

  top_state_e state, state_next;
  sums_t      sums;
  fit_t       solved;
  logic       acc_busy, solve_busy;
  logic       acc_start, solve_start, load;
  logic       last_q;
  logic       out_valid;
  fit_t       out_q;

  lspf_acc #(.MAX_POINTS(MAX_POINTS)) u_acc (
    .clk   (clk),
    .rst   (rst),
    .start (acc_start),
    .clear (load),
    .px    (point.px),
    .py    (point.py),
    .pz    (point.pz),
    .busy  (acc_busy),
    .sums  (sums)
  );

  lspf_solve u_solve (
    .clk   (clk),
    .rst   (rst),
    .start (solve_start),
    .sums  (sums),
    .busy  (solve_busy),
    .res   (solved)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    point.ready = 1'b0;
    acc_start   = 1'b0;
    solve_start = 1'b0;
    load        = 1'b0;
    unique case (state)
      T_IDLE: begin
        point.ready = 1'b1;
        if (point.valid) begin
          acc_start  = 1'b1;
          state_next = T_ACC;
        end
      end
      T_ACC: begin
        if (!acc_busy) begin
          solve_start = last_q;
          state_next  = last_q ? T_SOLVE : T_IDLE;
        end
      end
      T_SOLVE: begin
        if (!solve_busy) begin
          state_next = T_PUT;
        end
      end
      default: begin
        if (!out_valid || fit.ready) begin
          load       = 1'b1;
          state_next = T_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc_start) begin
      last_q <= point.last;
    end
    if (load) begin
      out_q <= solved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (fit.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign fit.valid    = out_valid;
  assign fit.slope_x  = out_q.slope_x;
  assign fit.slope_y  = out_q.slope_y;
  assign fit.offset   = out_q.offset;
  assign fit.z_spread = out_q.z_spread;
  assign fit.status   = out_q.status;

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(acc_busy && solve_busy))
    else $error("Accumulator and solver busy together.");

  a_result_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == T_PUT))
    else $error("Result item raised outside the output step.");

  a_cleared_after_result: assert property (@(posedge clk) disable iff (rst)
    load |=> sums.n == '0)
    else $error("Sums not cleared after a result item.");

endmodule

`default_nettype wire
